@@ src/cpra_pkg.sv @@
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared widths, types and codes of the contiguous page run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

  localparam int PAGE_BITS     = 40;
  localparam int COUNT_BITS    = 13;
  localparam int ALIGN_BITS    = 4;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int NUM_PAGES_DEF = 4096;
  localparam int WORD_BITS     = 8;

  typedef logic [PAGE_BITS-1:0]    page_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [ALIGN_BITS-1:0]   align_t;
  typedef logic [STATUS_BITS-1:0]  rsp_code_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam rsp_code_t ST_OK           = 2'd0;
  localparam rsp_code_t ST_NO_MEMORY    = 2'd1;
  localparam rsp_code_t ST_ALREADY_FREE = 2'd2;
  localparam rsp_code_t ST_OUT_OF_RANGE = 2'd3;

  localparam cfg_idx_t CFG_RANGE_BASE  = 2'd0;
  localparam cfg_idx_t CFG_RANGE_COUNT = 2'd1;

endpackage

@@ src/cpra_in_if.sv @@
// ----------------------------------------------------------------------------
// cpra_in_if
// Request channel: allocate or free one run of pages.
// ----------------------------------------------------------------------------
interface cpra_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  cpra_pkg::page_t     start_page;
  cpra_pkg::page_t     limit_page;
  cpra_pkg::count_t    run_pages;
  cpra_pkg::align_t    align_log2;

  modport source (output valid, kind, start_page, limit_page, run_pages, align_log2,
                  input ready);
  modport sink   (input valid, kind, start_page, limit_page, run_pages, align_log2,
                  output ready);
endinterface

@@ src/cpra_out_if.sv @@
// ----------------------------------------------------------------------------
// cpra_out_if
// Result channel: status, first page of the run and free page count.
// ----------------------------------------------------------------------------
interface cpra_out_if;
  logic                valid;
  logic                ready;
  cpra_pkg::rsp_code_t status;
  cpra_pkg::page_t     first_page;
  cpra_pkg::count_t    free_pages;

  modport source (output valid, status, first_page, free_pages, input ready);
  modport sink   (input valid, status, first_page, free_pages, output ready);
endinterface

@@ src/cpra_cfg_if.sv @@
// ----------------------------------------------------------------------------
// cpra_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface cpra_cfg_if;
  logic                valid;
  logic                ready;
  cpra_pkg::cfg_idx_t  index;
  cpra_pkg::page_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/contiguous_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// Bitmap allocator of contiguous, aligned runs of physical pages.
// ----------------------------------------------------------------------------
// The free map lives in one memory of 8-page rows (1 read, 1 write port).
// After reset a clearing pass over all ceil(NUM_PAGES/8) rows (512 by default)
// marks every page in use; no request is taken during it, register writes
// are. An allocate request is prepared and checked, then scans rows from the
// window start up to the row where the run completes (up to the window end on
// failure), then marks the rows the run covers and loads its result. A free
// request runs a check pass and then a write pass over the rows it covers.
// The scan rate of one row per cycle is set by the single read port and the
// 8-page run chain evaluated per row. A new request is accepted while the
// previous result still waits in the output register.
module contiguous_page_run_allocator #(
  parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cpra_in_if.sink     in_if,
  cpra_out_if.source  out_if,
  cpra_cfg_if.sink    cfg_if
);
  import cpra_pkg::*;

  localparam int ROWS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_BITS  = $clog2(ROWS);
  localparam int LANE_BITS = $clog2(WORD_BITS);
  localparam int OFF_BITS  = ROW_BITS + LANE_BITS + 1;
  localparam int EXT_BITS  = PAGE_BITS + 1;
  localparam int APOS_BITS = 16;
  localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(ROWS - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd5;
  localparam logic [3:0] S_MSET  = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]           state_r;
  page_t                base_r;
  count_t               pcount_r;
  logic [EXT_BITS-1:0]  end_r;

  logic                 kind_r;
  page_t                start_r;
  page_t                limit_r;
  count_t               cnt_r;
  align_t               align_r;

  logic [EXT_BITS-1:0]  lo_r;
  logic [EXT_BITS-1:0]  hi_r;
  logic                 free_bad_r;
  logic [APOS_BITS-1:0] amask_r;
  logic [APOS_BITS-1:0] apos_r;

  logic [OFF_BITS-1:0]  lo_off_r;
  logic [OFF_BITS-1:0]  hi_off_r;
  logic [OFF_BITS-1:0]  seg_lo_r;
  logic [OFF_BITS-1:0]  seg_hi_r;
  logic [OFF_BITS-1:0]  cand_r;
  count_t               run_r;
  logic [ROW_BITS-1:0]  row_r;
  logic                 mark_val_r;

  rsp_code_t            status_r;
  page_t                first_r;
  count_t               free_total_r;

  logic                 out_valid_r;
  rsp_code_t            out_status_r;
  page_t                out_first_r;
  count_t               out_free_r;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rdata_r;

  // combinational
  logic                 in_acc;
  logic                 out_load;
  logic [EXT_BITS-1:0]  cmin;
  logic [EXT_BITS-1:0]  end_sum;
  logic [EXT_BITS-1:0]  base_x;
  logic [OFF_BITS-1:0]  lo_off_c;
  logic [OFF_BITS-1:0]  hi_off_c;
  logic [OFF_BITS-1:0]  seg_lo_c;
  logic [OFF_BITS-1:0]  seg_hi_c;
  logic                 alloc_fail;
  logic [ROW_BITS-1:0]  scan_last;
  logic [ROW_BITS-1:0]  seg_last;
  logic [WORD_BITS-1:0] seg_mask;
  logic                 any_free;
  logic [OFF_BITS-1:0]  p_c;
  logic                 act_c;
  logic                 al_c;
  count_t               run_c;
  logic [OFF_BITS-1:0]  cand_c;
  logic                 found_c;
  logic                 rd_en;
  logic [ROW_BITS-1:0]  rd_addr;
  logic                 wr_en;
  logic [ROW_BITS-1:0]  wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign in_if.ready   = (state_r == S_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign in_acc        = in_if.valid && (state_r == S_IDLE);
  assign out_load      = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.first_page = out_first_r;
  assign out_if.free_pages = out_free_r;

  // effective range end, clipped to NUM_PAGES and the page number space
  assign base_x  = {1'b0, base_r};
  assign cmin    = (EXT_BITS'(pcount_r) > EXT_BITS'(NUM_PAGES)) ?
                   EXT_BITS'(NUM_PAGES) : EXT_BITS'(pcount_r);
  assign end_sum = base_x + cmin;

  assign lo_off_c   = OFF_BITS'(lo_r - base_x);
  assign hi_off_c   = OFF_BITS'(hi_r - base_x);
  assign seg_lo_c   = OFF_BITS'({1'b0, start_r} - base_x);
  assign seg_hi_c   = OFF_BITS'({1'b0, start_r} + EXT_BITS'(cnt_r) - base_x);
  assign alloc_fail = (cnt_r == '0) || (hi_r <= lo_r);

  assign scan_last = ROW_BITS'((hi_off_r - 1'b1) >> LANE_BITS);
  assign seg_last  = ROW_BITS'((seg_hi_r - 1'b1) >> LANE_BITS);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      seg_mask[k] = (OFF_BITS'({row_r, LANE_BITS'(k)}) >= seg_lo_r) &&
                    (OFF_BITS'({row_r, LANE_BITS'(k)}) <  seg_hi_r);
    end
  end
  assign any_free = |(rdata_r & seg_mask);

  // run chain over one row: aligned start, reset on a page in use
  always_comb begin
    run_c   = run_r;
    cand_c  = cand_r;
    found_c = 1'b0;
    p_c     = '0;
    act_c   = 1'b0;
    al_c    = 1'b0;
    for (int k = 0; k < WORD_BITS; k++) begin
      p_c   = OFF_BITS'({row_r, LANE_BITS'(k)});
      act_c = (p_c >= lo_off_r) && (p_c < hi_off_r) && !found_c;
      al_c  = ((apos_r + APOS_BITS'(k)) & amask_r) == '0;
      if (act_c && ((run_c != '0) || al_c)) begin
        if (run_c == '0) cand_c = p_c;
        if (!rdata_r[k]) begin
          run_c = '0;
        end else begin
          run_c = run_c + 1'b1;
          if (run_c == cnt_r) found_c = 1'b1;
        end
      end
    end
  end

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_r + 1'b1;
    unique case (state_r)
      S_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = (kind_r == KIND_ALLOC) ? lo_off_c[OFF_BITS-2:LANE_BITS] :
                                           seg_lo_c[OFF_BITS-2:LANE_BITS];
      end
      S_MSET: begin
        rd_en   = 1'b1;
        rd_addr = seg_lo_r[OFF_BITS-2:LANE_BITS];
      end
      S_SCAN, S_FCHK, S_MARK: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  assign wr_en   = (state_r == S_CLEAR) || (state_r == S_MARK);
  assign wr_addr = row_r;
  assign wr_data = (state_r == S_CLEAR) ? '0 :
                   mark_val_r ? (rdata_r | seg_mask) : (rdata_r & ~seg_mask);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // registers and configuration
  always_ff @(posedge clk) begin
    end_r <= end_sum[PAGE_BITS] ? {1'b1, PAGE_BITS'(0)} : end_sum;
    if (!rst_n) begin
      base_r   <= '0;
      pcount_r <= count_t'(4096);
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_RANGE_BASE)  base_r   <= cfg_if.data;
      if (cfg_if.index == CFG_RANGE_COUNT) pcount_r <= cfg_if.data[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      row_r        <= '0;
      free_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_first_r  <= first_r;
        out_free_r   <= free_total_r;
      end else if (out_if.ready) begin
        out_valid_r  <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          row_r <= row_r + 1'b1;
          if (row_r == LAST_ROW) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_if.kind;
            start_r <= in_if.start_page;
            limit_r <= in_if.limit_page;
            cnt_r   <= in_if.run_pages;
            align_r <= in_if.align_log2;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          lo_r <= (start_r > base_r) ? {1'b0, start_r} : base_x;
          hi_r <= ((limit_r != '0) && ({1'b0, limit_r} < end_r)) ? {1'b0, limit_r} : end_r;
          free_bad_r <= (cnt_r == '0) || (start_r < base_r) ||
                        (({1'b0, start_r} + EXT_BITS'(cnt_r)) > end_r);
          amask_r <= APOS_BITS'((17'd1 << align_r) - 17'd1);
          first_r <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (kind_r == KIND_ALLOC) begin
            if (alloc_fail) begin
              status_r <= ST_NO_MEMORY;
              state_r  <= S_FIN;
            end else begin
              lo_off_r <= lo_off_c;
              hi_off_r <= hi_off_c;
              row_r    <= lo_off_c[OFF_BITS-2:LANE_BITS];
              apos_r   <= base_r[APOS_BITS-1:0] +
                          APOS_BITS'({lo_off_c[OFF_BITS-1:LANE_BITS], LANE_BITS'(0)});
              run_r    <= '0;
              cand_r   <= '0;
              state_r  <= S_SCAN;
            end
          end else begin
            if (free_bad_r) begin
              status_r <= ST_OUT_OF_RANGE;
              state_r  <= S_FIN;
            end else begin
              seg_lo_r   <= seg_lo_c;
              seg_hi_r   <= seg_hi_c;
              row_r      <= seg_lo_c[OFF_BITS-2:LANE_BITS];
              mark_val_r <= 1'b1;
              state_r    <= S_FCHK;
            end
          end
        end
        S_SCAN: begin
          if (found_c) begin
            seg_lo_r   <= cand_c;
            seg_hi_r   <= cand_c + OFF_BITS'(cnt_r);
            mark_val_r <= 1'b0;
            state_r    <= S_MSET;
          end else if (row_r == scan_last) begin
            status_r <= ST_NO_MEMORY;
            state_r  <= S_FIN;
          end else begin
            row_r  <= row_r + 1'b1;
            apos_r <= apos_r + APOS_BITS'(WORD_BITS);
            run_r  <= run_c;
            cand_r <= cand_c;
          end
        end
        S_FCHK: begin
          if (any_free) begin
            status_r <= ST_ALREADY_FREE;
            state_r  <= S_FIN;
          end else if (row_r == seg_last) begin
            state_r <= S_MSET;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        S_MSET: begin
          row_r   <= seg_lo_r[OFF_BITS-2:LANE_BITS];
          first_r <= (kind_r == KIND_ALLOC) ? PAGE_BITS'(base_x + EXT_BITS'(seg_lo_r)) : '0;
          state_r <= S_MARK;
        end
        S_MARK: begin
          if (row_r == seg_last) begin
            free_total_r <= mark_val_r ? (free_total_r + cnt_r) : (free_total_r - cnt_r);
            status_r     <= ST_OK;
            state_r      <= S_FIN;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP))
    else $error("accepted request did not start");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !wr_en)
    else $error("free map written while no request active");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (row_r <= scan_last))
    else $error("scan ran past window end");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result lost at output register");
`endif

endmodule

@@ sim/contiguous_page_run_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator_tb
// Self-checking bench of the contiguous page run allocator. Random allocate
// and free requests run under several range settings. A bitmap model predicts
// each result, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator_tb;
  import cpra_pkg::*;

  localparam int MAP_PAGES   = NUM_PAGES_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic   kind;
    page_t  start_page;
    page_t  limit_page;
    count_t run_pages;
    align_t align_log2;
  } req_t;

  typedef struct packed {
    rsp_code_t status;
    page_t     first_page;
    count_t    free_pages;
  } rsp_t;

  typedef struct packed {
    page_t  first;
    count_t len;
  } run_t;

  class page_map_scoreboard;
    bit          free_map[MAP_PAGES];
    count_t      free_cnt;
    page_t       base;
    count_t      count;
    rsp_t        pending[$];
    run_t        held_runs[$];
    int          errors;
    int          n_checked;
    int          n_ok_alloc;
    int          n_ok_free;

    function new();
      foreach (free_map[i]) free_map[i] = 0;
      free_cnt = '0;
      base     = '0;
      count    = count_t'(MAP_PAGES);
      errors   = 0;
    endfunction

    function longint unsigned span();
      longint unsigned c;
      longint unsigned room;
      c    = count;
      room = (64'd1 << PAGE_BITS) - base;
      if (c > MAP_PAGES) c = MAP_PAGES;
      if (c > room) c = room;
      return c;
    endfunction

    function void note_input(req_t r);
      longint unsigned b, e, lo, hi, amask, run, cand, j, n;
      rsp_t            p;
      bit              clash;
      b = base;
      e = b + span();
      n = r.run_pages;
      p = '0;
      if (r.kind == KIND_ALLOC) begin
        lo    = (r.start_page > b) ? r.start_page : b;
        hi    = (r.limit_page != 0 && r.limit_page < e) ? r.limit_page : e;
        amask = (64'd1 << r.align_log2) - 1;
        p.status = ST_NO_MEMORY;
        run  = 0;
        cand = 0;
        if (n != 0 && hi > lo) begin
          for (j = lo - b; j < hi - b; j++) begin
            if (run == 0) begin
              if (((b + j) & amask) != 0) continue;
              cand = j;
            end
            if (!free_map[j]) begin
              run = 0;
              continue;
            end
            run++;
            if (run == n) begin
              for (longint unsigned k = cand; k < cand + n; k++) free_map[k] = 0;
              free_cnt     = free_cnt - count_t'(n);
              p.status     = ST_OK;
              p.first_page = page_t'(b + cand);
              held_runs.push_back('{page_t'(b + cand), count_t'(n)});
              n_ok_alloc++;
              break;
            end
          end
        end
      end else begin
        if (n == 0 || r.start_page < b || r.start_page + n > e) begin
          p.status = ST_OUT_OF_RANGE;
        end else begin
          clash = 0;
          for (longint unsigned k = r.start_page - b; k < r.start_page - b + n; k++)
            if (free_map[k]) clash = 1;
          if (clash) begin
            p.status = ST_ALREADY_FREE;
          end else begin
            for (longint unsigned k = r.start_page - b; k < r.start_page - b + n; k++)
              free_map[k] = 1;
            free_cnt = free_cnt + count_t'(n);
            p.status = ST_OK;
            n_ok_free++;
          end
        end
      end
      p.free_pages = free_cnt;
      pending.push_back(p);
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d first=%h free=%0d",
                 $time, got.status, got.first_page, got.free_pages);
        errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.first_page !== want.first_page) begin
        $display("%0t: first_page expected %h actual %h", $time, want.first_page,
                 got.first_page);
        errors++;
      end
      if (got.free_pages !== want.free_pages) begin
        $display("%0t: free_pages expected %0d actual %0d", $time, want.free_pages,
                 got.free_pages);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   tail_run;
  int   out_stall;
  int   quiet_cycles = 0;
  int   n_sent;

  cpra_in_if  in_if ();
  cpra_out_if out_if ();
  cpra_cfg_if cfg_if ();

  page_map_scoreboard sb;

  contiguous_page_run_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_if.valid && out_if.ready)
        sb.check('{out_if.status, out_if.first_page, out_if.free_pages});
      if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall    <= $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic page_t rand_page();
    return page_t'({$urandom, $urandom});
  endfunction

  task automatic send(req_t r);
    in_if.valid      <= 1'b1;
    in_if.kind       <= r.kind;
    in_if.start_page <= r.start_page;
    in_if.limit_page <= r.limit_page;
    in_if.run_pages  <= r.run_pages;
    in_if.align_log2 <= r.align_log2;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(r);
    n_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, page_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_RANGE_BASE) sb.base = value;
    else sb.count = count_t'(value);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(page_t b, count_t c);
    drain();
    write_reg(CFG_RANGE_BASE, b);
    write_reg(CFG_RANGE_COUNT, page_t'(c));
  endtask

  task automatic directed();
    req_t            r;
    longint unsigned b;
    b = sb.base;
    // free everything in two halves, then failing frees, then allocations and frees
    r = '{KIND_FREE, page_t'(b), '0, count_t'(2048), '0};     send(r);
    r = '{KIND_FREE, page_t'(b + 2048), '0, count_t'(2048), '0}; send(r);
    r = '{KIND_FREE, page_t'(b + 5), '0, count_t'(1), '0};   send(r);
    r = '{KIND_FREE, page_t'(b + 4095), '0, count_t'(2), '0}; send(r);
    r = '{KIND_FREE, page_t'(b), '0, count_t'(0), '0};       send(r);
    r = '{KIND_FREE, '1, '0, count_t'(1), '0};               send(r);
    r = '{KIND_ALLOC, '0, '0, count_t'(0), '0};              send(r);
    r = '{KIND_ALLOC, '0, '0, count_t'(1), '0};              send(r);
    r = '{KIND_ALLOC, '0, '0, count_t'(3), align_t'(2)};     send(r);
    r = '{KIND_ALLOC, page_t'(b + 100), '0, count_t'(7), align_t'(4)}; send(r);
    r = '{KIND_ALLOC, page_t'(b + 50), page_t'(b + 50), count_t'(1), '0}; send(r);
    r = '{KIND_ALLOC, page_t'(b + 60), page_t'(b + 10), count_t'(1), '0}; send(r);
    r = '{KIND_ALLOC, '1, '0, count_t'(1), '0};              send(r);
    r = '{KIND_ALLOC, '0, '1, count_t'(1), align_t'(12)};    send(r);
    r = '{KIND_ALLOC, '0, '0, count_t'(1), align_t'(15)};    send(r);
    r = '{KIND_ALLOC, '0, '0, count_t'(4096), '0};           send(r);
    r = '{KIND_ALLOC, '0, '0, '1, '0};                       send(r);
    r = '{KIND_FREE, page_t'(b + 200), '0, count_t'(3000), '0}; send(r);
    r = '{KIND_ALLOC, page_t'(b + 4000), '0, count_t'(96), align_t'(5)}; send(r);
    r = '{KIND_ALLOC, '0, page_t'(b + 4096), count_t'(2048), align_t'(11)}; send(r);
    r = '{KIND_FREE, page_t'(b + 4000), '0, count_t'(96), '0}; send(r);
  endtask

  task automatic random_items(int n);
    req_t            r;
    longint unsigned b, w;
    int              pick;
    run_t            h;
    b = sb.base;
    w = sb.span();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      r    = '0;
      if (pick < 40) begin
        r.kind       = KIND_ALLOC;
        r.run_pages  = ($urandom_range(0, 30) == 0) ? count_t'($urandom_range(1, 4096))
                                                    : count_t'($urandom_range(1, 16));
        r.align_log2 = ($urandom_range(0, 9) == 0) ? align_t'($urandom)
                                                   : align_t'($urandom_range(0, 4));
        r.start_page = ($urandom_range(0, 2) == 0) ? '0
                                                   : page_t'(b + $urandom_range(0, w));
        r.limit_page = ($urandom_range(0, 1) == 0) ? '0
                                                   : page_t'(b + $urandom_range(0, w + 8));
      end else if (pick < 75 && sb.held_runs.size() > 0) begin
        h            = sb.held_runs[$urandom_range(0, sb.held_runs.size() - 1)];
        r.kind       = KIND_FREE;
        r.start_page = h.first;
        r.run_pages  = h.len;
        r.limit_page = rand_page();
        r.align_log2 = align_t'($urandom);
        for (int k = 0; k < sb.held_runs.size(); k++)
          if (sb.held_runs[k] == h) begin
            sb.held_runs.delete(k);
            break;
          end
      end else if (pick < 90) begin
        r.kind       = KIND_FREE;
        r.start_page = page_t'(b + $urandom_range(0, w));
        r.run_pages  = count_t'($urandom_range(0, 24));
        r.limit_page = rand_page();
        r.align_log2 = align_t'($urandom);
      end else begin
        r.kind       = logic'($urandom);
        r.start_page = rand_page();
        r.limit_page = rand_page();
        r.run_pages  = count_t'($urandom);
        r.align_log2 = align_t'($urandom);
      end
      if (i % 60 == 0 && !tail_run) idle_on = ($urandom_range(0, 2) != 0);
      send(r);
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    idle_on      = 1'b1;
    tail_run     = 1'b0;
    n_sent       = 0;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_ALLOC;
    in_if.start_page = '0;
    in_if.limit_page = '0;
    in_if.run_pages  = '0;
    in_if.align_log2 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_RANGE_BASE;
    cfg_if.data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_range('0, count_t'(4096));
    directed();
    random_items(200);
    set_range(page_t'((64'd1 << PAGE_BITS) - 64), count_t'(4096));
    random_items(120);
    set_range(rand_page(), count_t'(1));
    random_items(50);
    set_range(page_t'($urandom_range(0, 1 << 20)), count_t'(300));
    random_items(130);
    set_range('0, count_t'(8191));
    random_items(120);
    set_range('0, count_t'(0));
    random_items(40);
    set_range('0, count_t'(4096));
    random_items(80);
    drain();
    tail_run = 1'b1;
    idle_on  = 1'b0;
    random_items(110);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests over 7 range settings: %0d allocations, %0d frees ok",
             n_sent, sb.n_ok_alloc, sb.n_ok_free);
    $display("%0d results checked, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
